FILE: sv/ncs_pkg.sv
// ncs_pkg: shared types and constants of the nearest-centroid search block
// field widths, action codes, sequencer states and the pipeline tag
// no dependencies
`default_nettype none

package ncs_pkg;

  localparam int CIDX_W    = 8;
  localparam int EIDX_W    = 7;
  localparam int ELEM_W    = 16;
  localparam int ACT_W     = 9;
  localparam int DIST_W    = 40;
  localparam int DIFF_W    = ELEM_W + 1;
  localparam int SQ_W      = 32;

  localparam logic [ACT_W-1:0]  ACT_RESET = 9'd256;
  localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};

  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } ncs_state_t;

  // travels beside the centroid element through the difference pipeline
  typedef struct packed {
    logic valid;
    logic zero;
  } ncs_tag_t;

endpackage

`default_nettype wire

FILE: sv/ncs_in_if.sv
// ncs_in_if: request channel into the nearest-centroid search block
// depends on ncs_pkg
`default_nettype none

interface ncs_in_if import ncs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [CIDX_W-1:0]        centroid_index;
  logic [EIDX_W-1:0]        element_index;
  logic signed [ELEM_W-1:0] element_value;
  logic                     last_element;

  modport source (output valid, action, centroid_index, element_index, element_value,
                  last_element, input ready);
  modport sink (input valid, action, centroid_index, element_index, element_value,
                last_element, output ready);
endinterface

`default_nettype wire

FILE: sv/ncs_out_if.sv
// ncs_out_if: result channel of the nearest-centroid search block
// depends on ncs_pkg
`default_nettype none

interface ncs_out_if import ncs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] best_centroid;
  logic [DIST_W-1:0] best_distance;

  modport source (output valid, best_centroid, best_distance, input ready);
  modport sink (input valid, best_centroid, best_distance, output ready);
endinterface

`default_nettype wire

FILE: sv/ncs_store.sv
// ncs_store: centroid element memory, one write and one registered read port
// depends on ncs_pkg
`default_nettype none

module ncs_store import ncs_pkg::*; #(
  parameter int DEPTH  = 32768,
  parameter int ADDR_W = 15
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [ADDR_W-1:0]        waddr,
  input  wire logic signed [ELEM_W-1:0] wdata,
  input  wire logic                     re,
  input  wire logic [ADDR_W-1:0]        raddr,
  output      logic signed [ELEM_W-1:0] rdata
);

  logic signed [ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/ncs_sqdiff.sv
// ncs_sqdiff: two-stage difference and square of centroid and query elements
// depends on ncs_pkg
`default_nettype none

module ncs_sqdiff import ncs_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire ncs_tag_t                 tag_i,
  input  wire logic signed [ELEM_W-1:0] cent,
  input  wire logic signed [ELEM_W-1:0] query,
  output      logic                     sq_valid,
  output      logic [SQ_W-1:0]          sq
);

  logic                     v1_r;
  logic                     v2_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [DIFF_W-1:0] diff_nxt;
  logic signed [2*DIFF_W-1:0] prod;
  logic [SQ_W-1:0]          sq_r;

  // an out-of-range element adds nothing
  assign diff_nxt = tag_i.zero ? '0 : ({cent[ELEM_W-1], cent} - {query[ELEM_W-1], query});
  assign prod     = diff_r * diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= tag_i.valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    // |diff| < 2^16, so the square fits in 32 bits
    sq_r   <= prod[SQ_W-1:0];
  end

  assign sq_valid = v2_r;
  assign sq       = sq_r;

endmodule

`default_nettype wire

FILE: sv/ncs_cell.sv
// ncs_cell: one running-distance accumulator in the rotating chain
// depends on ncs_pkg
`default_nettype none

module ncs_cell import ncs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              shift,
  input  wire logic [DIST_W-1:0] d_in,
  output      logic [DIST_W-1:0] d_out
);

  logic [DIST_W-1:0] dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= '0;
    end else if (shift) begin
      dist_r <= d_in;
    end
  end

  assign d_out = dist_r;

endmodule

`default_nettype wire

FILE: sv/nearest_centroid_search.sv
// nearest_centroid_search: squared-L2 nearest centroid over a rotating chain of accumulators
// a load request is taken in ST_IDLE, which it does not leave; a query element keeps the block busy
// in ST_RUN while one centroid-element read per cycle passes every centroid; a last element then
// waits in ST_FIN until the result register is free and loads its result into it
// reset (rst_n low, synchronous) zeroes all distances and sets the active count to 256;
// the centroid store is not cleared and must be loaded before queries
`default_nettype none

module nearest_centroid_search import ncs_pkg::*; #(
  parameter int NUM_CENTROIDS = 256,
  parameter int VECTOR_DIM    = 128
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [ACT_W-1:0] cfg_wdata,
  ncs_in_if.sink                in_req,
  ncs_out_if.source             out_res
);

  localparam int DEPTH  = NUM_CENTROIDS * VECTOR_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (NUM_CENTROIDS > 1) ? $clog2(NUM_CENTROIDS) : 1;
  localparam int CMP_W  = (IDX_W + 1 > ACT_W) ? IDX_W + 1 : ACT_W;
  localparam int WA_W   = CIDX_W + $clog2(VECTOR_DIM + 1);

  ncs_state_t state_r, state_nxt;
  logic       in_ready;
  logic       in_acc;
  logic       out_load;

  logic [ACT_W-1:0]         act_r;
  logic signed [ELEM_W-1:0] q_r;
  logic                     last_r;
  logic                     zero_r;
  logic                     iss_act_r;
  logic [IDX_W-1:0]         iss_r;
  logic [IDX_W-1:0]         hd_r;
  logic [ADDR_W-1:0]        rd_addr_r;
  ncs_tag_t                 tag_s1_r;

  logic [DIST_W-1:0]   best_dist_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic                out_valid_r;
  logic [CIDX_W-1:0]   out_idx_r;
  logic [DIST_W-1:0]   out_dist_r;
  logic [CIDX_W+IDX_W-1:0] best_pad;

  logic              ld_in_range;
  logic              q_in_range;
  logic [WA_W-1:0]   wr_full;
  logic signed [ELEM_W-1:0] cent_rd;
  logic              sq_valid;
  logic [SQ_W-1:0]   sq;
  logic              head_end;
  logic [DIST_W:0]   head_sum;
  logic [DIST_W-1:0] head_sat;
  logic [DIST_W-1:0] tail_val;
  logic [CMP_W-1:0]  act_ext;
  logic [CMP_W-1:0]  n_act;
  logic [DIST_W-1:0] chain [NUM_CENTROIDS+1];

  assign in_acc      = in_req.valid && in_ready;
  assign in_req.ready = in_ready;

  assign ld_in_range = (int'(in_req.centroid_index) < NUM_CENTROIDS) &&
                       (int'(in_req.element_index) < VECTOR_DIM);
  assign q_in_range  = int'(in_req.element_index) < VECTOR_DIM;
  assign wr_full     = WA_W'(in_req.centroid_index) * WA_W'(VECTOR_DIM) +
                       WA_W'(in_req.element_index);

  // active count clamped to 1..NUM_CENTROIDS
  assign act_ext = CMP_W'(act_r);
  always_comb begin
    if (act_r == '0) begin
      n_act = CMP_W'(1);
    end else if (act_ext > CMP_W'(NUM_CENTROIDS)) begin
      n_act = CMP_W'(NUM_CENTROIDS);
    end else begin
      n_act = act_ext;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_req.valid && in_req.action == ACTION_QUERY) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sq_valid && head_end) begin
          state_nxt = last_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_res.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= ACT_RESET;
    end else if (cfg_we) begin
      act_r <= cfg_wdata;
    end
  end

  // read issue: one centroid per cycle, address steps by one vector
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_act_r <= 1'b0;
      tag_s1_r  <= '0;
    end else begin
      tag_s1_r.valid <= iss_act_r;
      tag_s1_r.zero  <= zero_r;
      if (in_acc && in_req.action == ACTION_QUERY) begin
        iss_act_r <= 1'b1;
      end else if (iss_act_r && iss_r == IDX_W'(NUM_CENTROIDS - 1)) begin
        iss_act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_req.action == ACTION_QUERY) begin
      q_r       <= in_req.element_value;
      last_r    <= in_req.last_element;
      zero_r    <= !q_in_range;
      iss_r     <= '0;
      hd_r      <= '0;
      rd_addr_r <= q_in_range ? ADDR_W'(in_req.element_index) : '0;
    end else begin
      if (iss_act_r) begin
        iss_r     <= iss_r + IDX_W'(1);
        rd_addr_r <= rd_addr_r + ADDR_W'(VECTOR_DIM);
      end
      if (sq_valid) begin
        hd_r <= hd_r + IDX_W'(1);
      end
    end
  end

  ncs_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (in_acc && in_req.action == ACTION_LOAD && ld_in_range),
    .waddr (ADDR_W'(wr_full)),
    .wdata (in_req.element_value),
    .re    (iss_act_r),
    .raddr (rd_addr_r),
    .rdata (cent_rd)
  );

  ncs_sqdiff u_sqdiff (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_i    (tag_s1_r),
    .cent     (cent_rd),
    .query    (q_r),
    .sq_valid (sq_valid),
    .sq       (sq)
  );

  // head of the chain: saturating add, then back in at the tail
  assign head_end = hd_r == IDX_W'(NUM_CENTROIDS - 1);
  assign head_sum = {1'b0, chain[0]} + (DIST_W + 1)'(sq);
  assign head_sat = head_sum[DIST_W] ? DIST_MAX : head_sum[DIST_W-1:0];
  // the pass of a last element clears the distances behind it
  assign tail_val = last_r ? '0 : head_sat;
  assign chain[NUM_CENTROIDS] = tail_val;

  for (genvar i = 0; i < NUM_CENTROIDS; i++) begin : g_cell
    ncs_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (sq_valid),
      .d_in  (chain[i+1]),
      .d_out (chain[i])
    );
  end

  // strict less-than keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (sq_valid && last_r) begin
      if (hd_r == '0) begin
        best_dist_r <= head_sat;
        best_idx_r  <= '0;
      end else if (CMP_W'(hd_r) < n_act && head_sat < best_dist_r) begin
        best_dist_r <= head_sat;
        best_idx_r  <= hd_r;
      end
    end
  end

  assign best_pad = {{CIDX_W{1'b0}}, best_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r  <= best_pad[CIDX_W-1:0];
      out_dist_r <= best_dist_r;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.best_centroid = out_idx_r;
  assign out_res.best_distance = out_dist_r;

endmodule

`default_nettype wire

FILE: tb/ncs_result_check.sv
// ncs_result_check: watches the request, result and config ports of nearest_centroid_search,
// keeps its own centroid store and running distances and checks every result in order
// depends on ncs_pkg, ncs_in_if and ncs_out_if
`timescale 1ns / 1ps

module ncs_result_check import ncs_pkg::*; #(
  parameter int NUM_CENTROIDS = 256,
  parameter int VECTOR_DIM    = 128
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [ACT_W-1:0] cfg_wdata,
  ncs_in_if                     in_mon,
  ncs_out_if                    out_mon,
  output int                    mismatch_count,
  output int                    open_results,
  output int                    result_count
);

  typedef struct packed {
    logic [CIDX_W-1:0] centroid;
    logic [DIST_W-1:0] distance;
  } nearest_t;

  logic signed [ELEM_W-1:0] centroid_mem [NUM_CENTROIDS][VECTOR_DIM];
  logic [DIST_W-1:0]        dist_acc [NUM_CENTROIDS];
  logic [ACT_W-1:0]         active_setting;
  nearest_t                 nearest_due [$];

  // every centroid accumulates, whether or not it competes for the result
  function automatic void fold_query_element(input logic [EIDX_W-1:0] eidx,
                                             input logic signed [ELEM_W-1:0] q);
    longint          diff;
    longint unsigned sq;
    if (int'(eidx) >= VECTOR_DIM) return;
    for (int c = 0; c < NUM_CENTROIDS; c++) begin
      diff = longint'(centroid_mem[c][eidx]) - longint'(q);
      sq   = diff * diff;
      if (sq > DIST_MAX - dist_acc[c]) dist_acc[c] = DIST_MAX;
      else dist_acc[c] = dist_acc[c] + DIST_W'(sq);
    end
  endfunction

  // strict less-than keeps the lowest index on ties
  function automatic nearest_t pick_nearest();
    nearest_t best;
    int       n;
    n = int'(active_setting);
    if (n < 1) n = 1;
    if (n > NUM_CENTROIDS) n = NUM_CENTROIDS;
    best.centroid = '0;
    best.distance = dist_acc[0];
    for (int c = 1; c < n; c++) begin
      if (dist_acc[c] < best.distance) begin
        best.distance = dist_acc[c];
        best.centroid = CIDX_W'(c);
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin : watch
    nearest_t want;
    if (!rst_n) begin
      foreach (dist_acc[c]) dist_acc[c] = '0;
      active_setting = ACT_RESET;
      nearest_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        result_count++;
        if (nearest_due.size() == 0) begin
          $error("unexpected result: best_centroid %0d, best_distance %0d",
                 out_mon.best_centroid, out_mon.best_distance);
          mismatch_count++;
        end else begin
          want = nearest_due.pop_front();
          if (out_mon.best_centroid !== want.centroid) begin
            $error("best_centroid mismatch: expected %0d, got %0d",
                   want.centroid, out_mon.best_centroid);
            mismatch_count++;
          end
          if (out_mon.best_distance !== want.distance) begin
            $error("best_distance mismatch: expected %0d, got %0d",
                   want.distance, out_mon.best_distance);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) active_setting = cfg_wdata;
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == ACTION_LOAD) begin
          if (int'(in_mon.centroid_index) < NUM_CENTROIDS &&
              int'(in_mon.element_index) < VECTOR_DIM)
            centroid_mem[in_mon.centroid_index][in_mon.element_index] = in_mon.element_value;
        end else begin
          fold_query_element(in_mon.element_index, in_mon.element_value);
          if (in_mon.last_element) begin
            nearest_due = {nearest_due, pick_nearest()};
            foreach (dist_acc[c]) dist_acc[c] = '0;
          end
        end
      end
    end
    open_results = nearest_due.size();
  end

endmodule

FILE: tb/tb_nearest_centroid_search.sv
// tb_nearest_centroid_search: drives loads, queries and active-count writes into the block
// with random gaps and result stalls; ncs_result_check does the prediction and comparison
// depends on ncs_pkg, ncs_in_if, ncs_out_if, nearest_centroid_search and ncs_result_check
`timescale 1ns / 1ps

module tb_nearest_centroid_search;
  import ncs_pkg::*;

  localparam int NUM_CENTROIDS  = 256;
  localparam int VECTOR_DIM     = 128;
  localparam int RANDOM_ITEMS   = 960;
  localparam int SETTLE_CYCLES  = NUM_CENTROIDS + 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SAT_REPEATS    = 257;
  localparam int CFG_SPACING    = 220;
  localparam int EXTRA_COLUMNS  = 2;

  localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [ACT_W-1:0] cfg_wdata;
  int               mismatch_count;
  int               open_results;
  int               result_count;
  int               req_count;
  int               load_count;
  int               query_count;
  int               cfg_count;
  bit               calm;
  int               full_cols [$];
  bit               col_full [VECTOR_DIM];

  ncs_in_if  in_req ();
  ncs_out_if out_res ();

  nearest_centroid_search #(
    .NUM_CENTROIDS(NUM_CENTROIDS),
    .VECTOR_DIM   (VECTOR_DIM)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_req   (in_req),
    .out_res  (out_res)
  );

  ncs_result_check #(
    .NUM_CENTROIDS(NUM_CENTROIDS),
    .VECTOR_DIM   (VECTOR_DIM)
  ) nearest_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_mon        (in_req),
    .out_mon       (out_res),
    .mismatch_count(mismatch_count),
    .open_results  (open_results),
    .result_count  (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 320);
  endfunction

  function automatic logic signed [ELEM_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 10) return ELEM_MIN;
    if (r < 20) return ELEM_MAX;
    if (r < 25) return '0;
    if (r < 28) return '1;
    return ELEM_W'($urandom);
  endfunction

  // valid stays high from one request to the next when there is no gap
  task automatic send_req(input logic action, input logic [CIDX_W-1:0] cidx,
                          input logic [EIDX_W-1:0] eidx,
                          input logic signed [ELEM_W-1:0] value, input logic last);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.valid          <= 1'b1;
    in_req.action         <= action;
    in_req.centroid_index <= cidx;
    in_req.element_index  <= eidx;
    in_req.element_value  <= value;
    in_req.last_element   <= last;
    do @(posedge clk); while (!in_req.ready);
    req_count++;
    if (action == ACTION_LOAD) load_count++;
    else query_count++;
  endtask

  task automatic send_query(input int eidx, input logic signed [ELEM_W-1:0] value,
                            input logic last);
    send_req(ACTION_QUERY, CIDX_W'($urandom_range(255)), EIDX_W'(eidx), value, last);
  endtask

  task automatic send_noise_load();
    send_req(ACTION_LOAD, CIDX_W'($urandom_range(255)), EIDX_W'($urandom_range(127)),
             pick_value(), 1'($urandom_range(1)));
  endtask

  // a query reads its element from every centroid, so only whole columns are queried
  task automatic fill_column(input int col);
    for (int c = 0; c < NUM_CENTROIDS; c++)
      send_req(ACTION_LOAD, CIDX_W'(c), EIDX_W'(col), pick_value(),
               1'($urandom_range(9) == 0));
    if (!col_full[col]) begin
      col_full[col] = 1'b1;
      full_cols = {full_cols, col};
    end
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_req.valid <= 1'b0;
    while (open_results != 0) @(negedge clk);
  endtask

  // loads and open queries give no result, so the block gets time to finish them
  task automatic write_active(input logic [ACT_W-1:0] value);
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_count++;
  endtask

  initial begin : result_backpressure
    int stall;
    int hold;
    out_res.ready = 1'b0;
    forever begin
      stall = $urandom_range(99);
      if (stall < 45) stall = 0;
      else if (stall < 80) stall = $urandom_range(1, 4);
      else if (stall < 95) stall = $urandom_range(5, 30);
      else stall = $urandom_range(60, 250);
      hold = ($urandom_range(99) < 5) ? $urandom_range(500, 2000) : $urandom_range(1, 40);
      if (stall > 0) begin
        @(negedge clk);
        out_res.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_res.ready <= 1'b1;
      repeat (hold - 1) @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", quiet);
    $display("FAIL nearest_centroid_search");
    $finish;
  end

  initial begin : stimulus
    int               start_count;
    int               last_cfg;
    int               r;
    int               len;
    int               col;
    bit               pressure_done;
    logic [ACT_W-1:0] active_val;

    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    calm                  = 1'b0;
    pressure_done         = 1'b0;
    in_req.valid          = 1'b0;
    in_req.action         = ACTION_LOAD;
    in_req.centroid_index = '0;
    in_req.element_index  = '0;
    in_req.element_value  = '0;
    in_req.last_element   = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    fill_column(0);
    fill_column(VECTOR_DIM - 1);

    // extreme query values against both filled columns
    send_query(0, ELEM_MIN, 1'b0);
    send_query(VECTOR_DIM - 1, ELEM_MAX, 1'b1);
    // a load marked last gives no result
    send_req(ACTION_LOAD, CIDX_W'(5), EIDX_W'(3), 16'sh1234, 1'b1);
    // the same element twice accumulates twice
    send_query(0, '0, 1'b0);
    send_query(0, '0, 1'b0);
    send_query(VECTOR_DIM - 1, '1, 1'b1);
    send_query(VECTOR_DIM - 1, '0, 1'b1);

    // four identical centroids, all at distance zero: the lowest index wins
    for (int c = 0; c < 4; c++) begin
      send_req(ACTION_LOAD, CIDX_W'(c), EIDX_W'(0), 16'sd100, 1'b0);
      send_req(ACTION_LOAD, CIDX_W'(c), EIDX_W'(VECTOR_DIM - 1), -16'sd100, 1'b0);
    end
    write_active(ACT_W'(4));
    send_query(0, 16'sd100, 1'b0);
    send_query(VECTOR_DIM - 1, -16'sd100, 1'b1);

    // zero clamps to one centroid; drive its distance into saturation
    write_active('0);
    send_req(ACTION_LOAD, '0, '0, ELEM_MAX, 1'b0);
    for (int i = 0; i < SAT_REPEATS; i++)
      send_query(0, ELEM_MIN, i == SAT_REPEATS - 1);

    // all ones clamps to the full store
    write_active('1);
    send_query(VECTOR_DIM - 1, 16'sd12345, 1'b1);

    start_count = req_count;
    last_cfg    = req_count;
    while (req_count - start_count < RANDOM_ITEMS) begin
      if (req_count - last_cfg >= CFG_SPACING) begin
        case ($urandom_range(7))
          0:       active_val = ACT_W'(1);
          1:       active_val = '0;
          2:       active_val = ACT_W'(255);
          3:       active_val = ACT_W'(256);
          4:       active_val = ACT_W'(257);
          5:       active_val = '1;
          6:       active_val = ACT_W'($urandom_range(2, 255));
          default: active_val = ACT_W'($urandom_range(511));
        endcase
        write_active(active_val);
        last_cfg = req_count;
      end
      if ($urandom_range(99) < 8) calm = !calm;
      r = $urandom_range(99);
      if (r < 60) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(99) < 8) send_noise_load();
          send_query(full_cols[$urandom_range(full_cols.size() - 1)], pick_value(),
                     i == len - 1);
        end
      end else if (r < 89) begin
        repeat ($urandom_range(1, 4)) send_noise_load();
      end else if (r < 90 && full_cols.size() < 2 + EXTRA_COLUMNS) begin
        do col = $urandom_range(1, VECTOR_DIM - 2); while (col_full[col]);
        fill_column(col);
      end else begin
        // query left open: it runs on into the next one
        repeat ($urandom_range(1, 3))
          send_query(full_cols[$urandom_range(full_cols.size() - 1)], pick_value(), 1'b0);
      end
      if (!pressure_done && req_count - start_count > RANDOM_ITEMS / 2) begin
        wait_results();
        pressure_done = 1'b1;
      end
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("covered %0d requests: %0d centroid loads, %0d query elements, %0d full columns",
             req_count, load_count, query_count, full_cols.size());
    $display("checked %0d nearest-centroid results across %0d active-count settings",
             result_count, cfg_count + 1);
    if (mismatch_count == 0 && open_results == 0)
      $display("PASS nearest_centroid_search");
    else
      $display("FAIL nearest_centroid_search");
    $finish;
  end

endmodule
